>>> design/vmac_pkg.sv
package vmac_pkg;

   localparam int unsigned LANES     = 8;
   localparam int unsigned LANE_W    = 16;
   localparam int unsigned ACC_W     = 48;
   localparam int unsigned PROD_W    = 33;
   localparam int unsigned VEC_W     = LANES * LANE_W;
   localparam int unsigned LANE_IDX_W = $clog2(LANES);
   // accumulator bits at and above this one must agree for an unclamped result
   localparam int unsigned CLAMP_MSB = 31;

   localparam logic [LANE_W-1:0] CLAMP_HIGH = 16'hFFFF;
   localparam logic [LANE_W-1:0] CLAMP_LOW  = 16'h0000;

   typedef enum logic {
      OP_MUL = 1'b0,
      OP_MAC = 1'b1
   } op_type;

   // lane and element masks for the four narrow broadcast groups
   localparam logic [2:0] LANE_MASK_BY_GROUP [4] = '{3'h7, 3'h6, 3'h4, 3'h4};
   localparam logic [2:0] ELEM_MASK_BY_GROUP [4] = '{3'h0, 3'h1, 3'h3, 3'h3};

   typedef struct packed {
      op_type      operation;
      logic [3:0]  element;
      logic [63:0] vs_lanes_0_3;
      logic [63:0] vs_lanes_4_7;
      logic [63:0] vt_lanes_0_3;
      logic [63:0] vt_lanes_4_7;
   } req_type;

   typedef struct packed {
      logic [63:0] result_lanes_0_3;
      logic [63:0] result_lanes_4_7;
   } rsp_type;

   // second-vector lane feeding a given lane under the broadcast selector
   function automatic logic [LANE_IDX_W-1:0] src_lane(input logic [3:0] element,
                                                      input logic [LANE_IDX_W-1:0] lane);
      logic [2:0] group;
      logic [2:0] lmask;
      logic [2:0] emask;
      group = element[3:1];
      if (group inside {[3'd4:3'd7]}) begin
         lmask = 3'h0;
         emask = 3'h7;
      end else begin
         lmask = LANE_MASK_BY_GROUP[group[1:0]];
         emask = ELEM_MASK_BY_GROUP[group[1:0]];
      end
      return (lane & lmask) + (element[2:0] & emask);
   endfunction

   // 16-bit lane result from the new 48-bit accumulator value
   function automatic logic [LANE_W-1:0] clamp_lane(input logic [ACC_W-1:0] acc);
      logic [ACC_W-1-CLAMP_MSB:0] high_bits;
      logic [LANE_W-1:0]          res;
      high_bits = acc[ACC_W-1:CLAMP_MSB];
      if ((&high_bits) || !(|high_bits)) begin
         res = acc[LANE_W-1:0];
      end else if (acc[ACC_W-1]) begin
         res = CLAMP_LOW;
      end else begin
         res = CLAMP_HIGH;
      end
      return res;
   endfunction

endpackage

>>> design/vmac_req_if.sv
interface vmac_req_if import vmac_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> design/vmac_rsp_if.sv
interface vmac_rsp_if import vmac_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> design/vector_mul_acc_clamp_8lane.sv
// Eight-lane 16-bit vector multiply / multiply-accumulate with clamped results.
// Request channel (req_chan): operation, broadcast element selector and two
// 128-bit vectors split into 64-bit halves. Response channel (rsp_chan): the
// eight clamped 16-bit lane results, one response per request, in order.
// Each lane keeps a 48-bit accumulator; a multiply overwrites it, a
// multiply-accumulate adds the product to it.
// A request passes through the input register, then the lane datapath into
// the output register, before it is presented on rsp_chan.
// Throughput: one request per cycle while rsp_chan is not stalled; the
// accumulator update of one request is visible to the very next one. The
// datapath stage is one 17x16 multiply and a 48-bit add per lane.
// Reset (synchronous, active high) clears both stage valids and all lane
// accumulators to zero.
// When the receiver stalls, the output register holds its response; the input
// register still takes one more request, after which req_chan.ready drops
// until the response is taken.
module vector_mul_acc_clamp_8lane
   import vmac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   vmac_req_if.sink    req_chan,
   vmac_rsp_if.source  rsp_chan
);

   logic                 s1_valid_ff, s1_valid_in;
   req_type              s1_req_ff;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_data_ff;
   rsp_type              out_data_in;
   logic [ACC_W-1:0]     acc_ff [LANES];
   logic [ACC_W-1:0]     acc_in [LANES];
   logic                 s1_advance;
   logic                 req_take;
   logic [VEC_W-1:0]     vs_all;
   logic [VEC_W-1:0]     vt_all;
   logic [VEC_W-1:0]     res_all;

   // handshake: the datapath stage moves when the output register is free
   assign s1_advance     = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_advance);
   assign out_valid_in = s1_advance || (out_valid_ff && !rsp_chan.ready);

   assign vs_all = {s1_req_ff.vs_lanes_4_7, s1_req_ff.vs_lanes_0_3};
   assign vt_all = {s1_req_ff.vt_lanes_4_7, s1_req_ff.vt_lanes_0_3};

   // lane datapath: multiply, optional accumulate, clamp
   always_comb begin
      logic [LANE_IDX_W-1:0]   src;
      logic [LANE_W-1:0]       s_op;
      logic signed [LANE_W-1:0] t_op;
      logic signed [PROD_W-1:0] prod;
      logic [ACC_W-1:0]        prod_ext;
      logic [ACC_W-1:0]        sum;
      res_all = '0;
      for (int i = 0; i < LANES; i++) begin
         src      = src_lane(s1_req_ff.element, LANE_IDX_W'(i));
         s_op     = vs_all[i*LANE_W +: LANE_W];
         t_op     = $signed(vt_all[src*LANE_W +: LANE_W]);
         prod     = $signed({1'b0, s_op}) * t_op;
         prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
         if (s1_req_ff.operation == OP_MAC) begin
            sum = acc_ff[i] + prod_ext;
         end else begin
            sum = prod_ext;
         end
         acc_in[i] = s1_advance ? sum : acc_ff[i];
         res_all[i*LANE_W +: LANE_W] = clamp_lane(sum);
      end
   end

   assign out_data_in.result_lanes_0_3 = res_all[VEC_W/2-1:0];
   assign out_data_in.result_lanes_4_7 = res_all[VEC_W-1:VEC_W/2];

   // control and accumulator state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < LANES; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         for (int i = 0; i < LANES; i++) begin
            acc_ff[i] <= acc_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= req_chan.data;
      end
      if (s1_advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

endmodule

>>> design/vmac_checker.sv
module vmac_checker
   import vmac_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled response stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   // every accepted request is followed by a valid response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("response missing two cycles after request");

   // back pressure on requests only comes from a pending response
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no response pending");

endmodule

bind vector_mul_acc_clamp_8lane vmac_checker u_vmac_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
   import vmac_pkg::*;
();

   // expected lane results of one request
   typedef struct packed {
      logic [63:0] result_lanes_0_3;
      logic [63:0] result_lanes_4_7;
   } lane_results;

   // one row of the directed table
   typedef struct {
      req_type     item;
      bit          typed;
      lane_results want;
   } stim_row;

   localparam int unsigned STALL_LIMIT  = 5000;
   localparam int unsigned RANDOM_ITEMS = 1100;
   localparam int unsigned WRAP_ITEMS   = 8;
   localparam logic [63:0] ALL_ZERO     = 64'h0000_0000_0000_0000;
   localparam logic [63:0] ALL_ONE      = 64'h0001_0001_0001_0001;
   localparam logic [63:0] ALL_FFFF     = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] ALL_7FFF     = 64'h7FFF_7FFF_7FFF_7FFF;
   localparam logic [63:0] ALL_8000     = 64'h8000_8000_8000_8000;

   logic clock = 1'b0;
   logic reset;

   vmac_req_if request_bus ();
   vmac_rsp_if result_bus ();

   vector_mul_acc_clamp_8lane dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (request_bus),
      .rsp_chan (result_bus)
   );

   always #5 clock = ~clock;

   logic [47:0]  lane_acc [LANES];
   lane_results  expected_results [$];
   stim_row      directed_rows [$];
   int unsigned  error_count = 0;
   int unsigned  tx_idle_pct = 11;
   int unsigned  rx_idle_pct = 70;
   int unsigned  stall_cycles = 0;

   // second-vector lane feeding lane idx under the broadcast selector
   function automatic int unsigned source_lane(input logic [3:0] element,
                                               input int unsigned idx);
      if (element[3]) begin
         return element[2:0];
      end else if (element[2]) begin
         return (idx & 4) + element[1:0];
      end else if (element[1]) begin
         return (idx & 6) + element[0];
      end
      return idx;
   endfunction

   // multiply / accumulate all lanes, update accumulators, clamp results
   task automatic mac_lanes(input req_type item, output lane_results res);
      logic [127:0]       vs_all;
      logic [127:0]       vt_all;
      logic [127:0]       out_all;
      logic [15:0]        a;
      logic [15:0]        b;
      logic signed [32:0] prod;
      logic [47:0]        acc_next;
      logic [16:0]        high_bits;
      vs_all = {item.vs_lanes_4_7, item.vs_lanes_0_3};
      vt_all = {item.vt_lanes_4_7, item.vt_lanes_0_3};
      out_all = '0;
      for (int unsigned i = 0; i < LANES; i++) begin
         a = vs_all[16*i +: 16];
         b = vt_all[16*source_lane(item.element, i) +: 16];
         prod = $signed({1'b0, a}) * $signed(b);
         acc_next = {{15{prod[32]}}, prod};
         if (item.operation == OP_MAC) begin
            acc_next = acc_next + lane_acc[i];
         end
         lane_acc[i] = acc_next;
         high_bits = acc_next[47:31];
         if (high_bits == '0 || high_bits == '1) begin
            out_all[16*i +: 16] = acc_next[15:0];
         end else if (acc_next[47]) begin
            out_all[16*i +: 16] = 16'h0000;
         end else begin
            out_all[16*i +: 16] = 16'hFFFF;
         end
      end
      res.result_lanes_0_3 = out_all[63:0];
      res.result_lanes_4_7 = out_all[127:64];
   endtask

   // present one request, wait for its acceptance, record the expectation
   task automatic send_request(input req_type item, input bit typed,
                               input lane_results typed_want);
      lane_results want;
      while ($urandom_range(99) < tx_idle_pct) begin
         request_bus.valid <= 1'b0;
         @(posedge clock);
      end
      request_bus.valid <= 1'b1;
      request_bus.data  <= item;
      @(posedge clock);
      while (!request_bus.ready) @(posedge clock);
      mac_lanes(item, want);
      expected_results.push_back(typed ? typed_want : want);
   endtask

   task automatic add_row(input op_type op, input logic [3:0] element,
                          input logic [63:0] vs0, input logic [63:0] vs1,
                          input logic [63:0] vt0, input logic [63:0] vt1,
                          input bit typed, input logic [63:0] w0,
                          input logic [63:0] w1);
      stim_row row;
      row.item.operation    = op;
      row.item.element      = element;
      row.item.vs_lanes_0_3 = vs0;
      row.item.vs_lanes_4_7 = vs1;
      row.item.vt_lanes_0_3 = vt0;
      row.item.vt_lanes_4_7 = vt1;
      row.typed             = typed;
      row.want              = {w0, w1};
      directed_rows.push_back(row);
   endtask

   // lane value biased toward the extremes
   function automatic logic [15:0] pick_lane();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h7FFF;
         3: return 16'h8000;
         4: return 16'h0001;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] pick_vector();
      if ($urandom_range(3) == 0) begin
         return {$urandom, $urandom};
      end
      return {pick_lane(), pick_lane(), pick_lane(), pick_lane()};
   endfunction

   // result side: random stall and in-order comparison
   always @(posedge clock) begin : result_check
      lane_results want;
      if (reset) begin
         result_bus.ready <= 1'b0;
      end else begin
         if (result_bus.valid && result_bus.ready) begin
            if (expected_results.size() == 0) begin
               $error("result with no request outstanding: %h",
                      result_bus.data);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (result_bus.data.result_lanes_0_3 !== want.result_lanes_0_3) begin
                  $error("result_lanes_0_3 expected %h actual %h",
                         want.result_lanes_0_3, result_bus.data.result_lanes_0_3);
                  error_count++;
               end
               if (result_bus.data.result_lanes_4_7 !== want.result_lanes_4_7) begin
                  $error("result_lanes_4_7 expected %h actual %h",
                         want.result_lanes_4_7, result_bus.data.result_lanes_4_7);
                  error_count++;
               end
            end
         end
         result_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (!reset) begin
         if ((request_bus.valid && request_bus.ready) ||
             (result_bus.valid && result_bus.ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      req_type item;
      stim_row row;
      reset               <= 1'b1;
      request_bus.valid   <= 1'b0;
      request_bus.data    <= '0;
      for (int unsigned i = 0; i < LANES; i++) lane_acc[i] = '0;

      // directed table: zeros, unit values, clamp limits, boundaries, selectors
      add_row(OP_MUL, 4'd0, ALL_ZERO, ALL_ZERO, ALL_ZERO, ALL_ZERO,
              1'b1, ALL_ZERO, ALL_ZERO);
      add_row(OP_MUL, 4'd0, ALL_ONE, ALL_ONE, ALL_ONE, ALL_ONE,
              1'b1, ALL_ONE, ALL_ONE);
      add_row(OP_MUL, 4'd0, ALL_ONE, ALL_ONE, ALL_FFFF, ALL_FFFF,
              1'b1, ALL_FFFF, ALL_FFFF);
      add_row(OP_MAC, 4'd0, ALL_ZERO, ALL_ZERO, ALL_ZERO, ALL_ZERO,
              1'b1, ALL_FFFF, ALL_FFFF);
      add_row(OP_MUL, 4'd0, ALL_FFFF, ALL_FFFF, ALL_7FFF, ALL_7FFF,
              1'b0, ALL_ZERO, ALL_ZERO);
      add_row(OP_MAC, 4'd0, ALL_FFFF, ALL_FFFF, ALL_7FFF, ALL_7FFF,
              1'b1, ALL_FFFF, ALL_FFFF);
      add_row(OP_MUL, 4'd0, ALL_FFFF, ALL_FFFF, ALL_8000, ALL_8000,
              1'b0, ALL_ZERO, ALL_ZERO);
      add_row(OP_MAC, 4'd0, ALL_FFFF, ALL_FFFF, ALL_8000, ALL_8000,
              1'b1, ALL_ZERO, ALL_ZERO);
      // accumulator walked across the low clamp boundary
      add_row(OP_MUL, 4'd0, ALL_8000, ALL_8000, ALL_8000, ALL_8000,
              1'b0, ALL_ZERO, ALL_ZERO);
      add_row(OP_MAC, 4'd0, ALL_8000, ALL_8000, ALL_8000, ALL_8000,
              1'b0, ALL_ZERO, ALL_ZERO);
      add_row(OP_MAC, 4'd0, ALL_ONE, ALL_ONE, ALL_ONE, ALL_ONE,
              1'b0, ALL_ZERO, ALL_ZERO);
      add_row(OP_MAC, 4'd0, 64'h0002_0002_0002_0002, 64'h0002_0002_0002_0002,
              ALL_FFFF, ALL_FFFF, 1'b0, ALL_ZERO, ALL_ZERO);
      // every broadcast selector
      for (int e = 0; e < 16; e++) begin
         add_row(e[0] ? OP_MAC : OP_MUL, e[3:0],
                 64'h0004_0003_0002_0001, 64'hFFFF_8000_0006_0005,
                 64'h0400_0300_0200_0100, 64'hFC00_FD00_FE00_FF00,
                 1'b0, ALL_ZERO, ALL_ZERO);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_request(row.item, row.typed, row.want);
      end

      // random part in three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 70 : 0;
         rx_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 11 : 0;
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            item.operation    = ($urandom_range(3) != 0) ? OP_MAC : OP_MUL;
            item.element      = 4'($urandom_range(15));
            item.vs_lanes_0_3 = pick_vector();
            item.vs_lanes_4_7 = pick_vector();
            item.vt_lanes_0_3 = pick_vector();
            item.vt_lanes_4_7 = pick_vector();
            send_request(item, 1'b0, '0);
         end
      end

      // repeated accumulation held beyond both clamp limits
      item.operation    = OP_MUL;
      item.element      = 4'd0;
      item.vs_lanes_0_3 = ALL_FFFF;
      item.vs_lanes_4_7 = ALL_FFFF;
      item.vt_lanes_0_3 = ALL_7FFF;
      item.vt_lanes_4_7 = ALL_8000;
      send_request(item, 1'b0, '0);
      item.operation = OP_MAC;
      for (int n = 0; n < WRAP_ITEMS; n++) begin
         send_request(item, 1'b0, '0);
      end
      request_bus.valid <= 1'b0;

      // drain
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
design/vmac_pkg.sv
design/vmac_req_if.sv
design/vmac_rsp_if.sv
design/vector_mul_acc_clamp_8lane.sv
design/vmac_checker.sv
tb/tb_top.sv
